// ===== sv/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg: block transfer sequencer shared definitions
// result kinds, address constants, the work descriptor and the bit helpers
// ----------------------------------------------------------------------------
package bts_pkg;

  typedef enum logic [1:0] {
    KIND_XFER  = 2'd0,
    KIND_WB    = 2'd1,
    KIND_PATCH = 2'd2
  } kind_t;

  localparam logic [31:0] WORD_STEP       = 32'h4;
  localparam logic [31:0] EMPTY_SPAN      = 32'h40;
  localparam logic [31:0] EMPTY_DOWN_POST = 32'h3C;
  localparam logic [3:0]  PC_REG          = 4'hF;
  localparam logic [15:0] PC_ONLY_LIST    = 16'h8000;

  // one classified instruction, as the back end carries it out
  typedef struct packed {
    logic        ld;
    logic        up;
    logic        user;
    logic        restore;
    logic        wb_emit;
    logic        patch_emit;
    logic [3:0]  rb;
    logic [15:0] list;
    logic [31:0] first_addr;
    logic [31:0] new_base;
  } desc_t;

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    logic [2:0] nib [4];
    for (int i = 0; i < 4; i++) begin
      nib[i] = {2'b00, v[4*i]} + {2'b00, v[4*i+1]} + {2'b00, v[4*i+2]} + {2'b00, v[4*i+3]};
    end
    return ({2'b00, nib[0]} + {2'b00, nib[1]}) + ({2'b00, nib[2]} + {2'b00, nib[3]});
  endfunction

  function automatic logic [3:0] lowest_set(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  function automatic logic [3:0] highest_set(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

// ===== sv/bts_req_if.sv =====
// ----------------------------------------------------------------------------
// bts_req_if: instruction channel
// one decoded block transfer and its base value per word
// ----------------------------------------------------------------------------
interface bts_req_if;
  logic        valid;
  logic        ready;
  logic        is_load;
  logic        pre_index;
  logic        step_up;
  logic        user_bank_bit;
  logic        write_back;
  logic [3:0]  base_reg;
  logic [15:0] reg_list;
  logic [31:0] base_value;
  logic        thumb_form;

  modport source (
    output valid, is_load, pre_index, step_up, user_bank_bit, write_back,
           base_reg, reg_list, base_value, thumb_form,
    input  ready
  );

  modport sink (
    input  valid, is_load, pre_index, step_up, user_bank_bit, write_back,
           base_reg, reg_list, base_value, thumb_form,
    output ready
  );
endinterface

// ===== sv/bts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bts_rsp_if: result channel
// one memory transfer, base writeback or patch store per word
// ----------------------------------------------------------------------------
interface bts_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [3:0]  reg_index;
  logic        load_op;
  logic        pc_plus_four;
  logic        user_mode;
  logic        flush_pipe;
  logic        restore_cpsr;
  logic        last;

  modport source (
    output valid, kind, address, reg_index, load_op, pc_plus_four, user_mode,
           flush_pipe, restore_cpsr, last,
    input  ready
  );

  modport sink (
    input  valid, kind, address, reg_index, load_op, pc_plus_four, user_mode,
           flush_pipe, restore_cpsr, last,
    output ready
  );
endinterface

// ===== sv/block_transfer_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// block_transfer_sequencer_core: load/store multiple sequencer
// expands one block transfer instruction into its ordered memory words
// ----------------------------------------------------------------------------
// req takes one decoded instruction word with its base value; rsp gives the
// memory transfers in register order, then the base writeback, then the
// patch store of the new base where one is due. last marks the final word.
// the intake stage registers the word and classifies it into a queue of
// QUEUE_DEPTH descriptors; the sequencer behind it pops one descriptor,
// loads it and then emits one result word per cycle while rsp is not
// stalled. on its way to the first result a word passes the intake
// register, a queue entry, the sequencer's descriptor register and its
// output register.
// a stall on rsp holds the output word; req keeps being accepted until the
// queue and the intake register are full. reset empties the intake, the
// queue and the sequencer; no word is pending afterwards.
// ----------------------------------------------------------------------------
module block_transfer_sequencer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  bts_req_if.sink   req,
  bts_rsp_if.source rsp
);

  bts_pkg::desc_t f_desc;
  bts_pkg::desc_t q_desc;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_avail;

  bts_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .desc (f_desc),
    .push (q_push),
    .full (q_full)
  );

  bts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (f_desc),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_desc),
    .avail (q_avail)
  );

  bts_back u_back (
    .clk   (clk),
    .rst   (rst),
    .desc  (q_desc),
    .avail (q_avail),
    .pop   (q_pop),
    .rsp   (rsp)
  );

`ifndef NO_ASSERTIONS
  a_patch_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.kind == bts_pkg::KIND_PATCH) |-> rsp.last)
    else $error("patch store not marked last");

  a_restore_on_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.restore_cpsr |-> rsp.last)
    else $error("cpsr restore away from final word");

  a_flush_pc_load: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.flush_pipe |->
      (rsp.kind == bts_pkg::KIND_XFER) && rsp.load_op && (rsp.reg_index == bts_pkg::PC_REG))
    else $error("flush without pc load");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("descriptor pushed into full queue");
`endif

endmodule

// ===== sv/bts_front.sv =====
// ----------------------------------------------------------------------------
// bts_front: instruction intake and classification
// registers one instruction word and turns it into a work descriptor
// ----------------------------------------------------------------------------
module bts_front (
  input  logic           clk,
  input  logic           rst,
  bts_req_if.sink        req,
  output bts_pkg::desc_t desc,
  output logic           push,
  input  logic           full
);

  logic        held;
  logic        h_ld;
  logic        h_pre;
  logic        h_up;
  logic        h_s;
  logic        h_wb;
  logic [3:0]  h_rb;
  logic [15:0] h_list;
  logic [31:0] h_base;
  logic        h_th;

  logic        s_eff;
  logic        wb_eff;
  logic        empty;
  logic        restore;
  logic        inlist;
  logic        first;
  logic [15:0] below_mask;
  logic [31:0] span;
  logic [31:0] near_addr;

  assign req.ready = !held || !full;
  assign push      = held && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req.ready) begin
      held <= req.valid;
    end
    if (req.valid && req.ready) begin
      h_ld   <= req.is_load;
      h_pre  <= req.pre_index;
      h_up   <= req.step_up;
      h_s    <= req.user_bank_bit;
      h_wb   <= req.write_back;
      h_rb   <= req.base_reg;
      h_list <= req.reg_list;
      h_base <= req.base_value;
      h_th   <= req.thumb_form;
    end
  end

  always_comb begin
    s_eff      = h_s && !h_th;
    wb_eff     = h_wb || h_th;
    empty      = (h_list == 16'h0000);
    restore    = s_eff && h_ld && h_list[15];
    inlist     = h_list[h_rb];
    below_mask = (16'h0001 << h_rb) - 16'h0001;
    first      = inlist && ((h_list & below_mask) == 16'h0000);
    span       = {25'd0, bts_pkg::popcount16(h_list), 2'b00};
    near_addr  = h_up ? (h_pre ? h_base + bts_pkg::WORD_STEP : h_base)
                      : (h_pre ? h_base - bts_pkg::WORD_STEP : h_base);

    desc.ld = h_ld;
    desc.up = h_up;
    desc.rb = h_rb;
    if (empty) begin
      desc.user       = 1'b0;
      desc.restore    = 1'b0;
      desc.wb_emit    = 1'b1;
      desc.patch_emit = 1'b0;
      desc.list       = bts_pkg::PC_ONLY_LIST;
      desc.first_addr = h_up ? near_addr
                             : (h_pre ? h_base - bts_pkg::EMPTY_SPAN
                                      : h_base - bts_pkg::EMPTY_DOWN_POST);
      desc.new_base   = h_up ? h_base + bts_pkg::EMPTY_SPAN : h_base - bts_pkg::EMPTY_SPAN;
    end else begin
      desc.user       = s_eff && !restore;
      desc.restore    = restore;
      desc.wb_emit    = wb_eff && !(h_ld && inlist);
      desc.patch_emit = wb_eff && !h_ld && !h_th && inlist && !first;
      desc.list       = h_list;
      desc.first_addr = near_addr;
      desc.new_base   = h_up ? h_base + span : h_base - span;
    end
  end

endmodule

// ===== sv/bts_queue.sv =====
// ----------------------------------------------------------------------------
// bts_queue: descriptor queue
// short first-in first-out store between intake and sequencer
// ----------------------------------------------------------------------------
module bts_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bts_pkg::desc_t din,
  output logic           full,
  input  logic           pop,
  output bts_pkg::desc_t dout,
  output logic           avail
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bts_pkg::desc_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == FULL_CNT);
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && avail;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== sv/bts_back.sv =====
// ----------------------------------------------------------------------------
// bts_back: transfer sequencer
// walks the register list one word per cycle unless rsp stalls, then writeback and patch
// ----------------------------------------------------------------------------
module bts_back (
  input  logic           clk,
  input  logic           rst,
  input  bts_pkg::desc_t desc,
  input  logic           avail,
  output logic           pop,
  bts_rsp_if.source      rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_XFER, ST_WB, ST_PATCH} state_t;

  state_t         state;
  state_t         xfer_next;
  bts_pkg::desc_t d;
  logic [15:0]    rem;
  logic [31:0]    addr;
  logic [31:0]    patch_addr;
  logic [3:0]     sel;
  logic           one_left;
  logic           xfer_last;
  logic           pc_sel;
  logic           adv;

  logic        o_valid;
  logic [1:0]  o_kind;
  logic [31:0] o_addr;
  logic [3:0]  o_reg;
  logic        o_load;
  logic        o_pc4;
  logic        o_user;
  logic        o_flush;
  logic        o_restore;
  logic        o_last;

  assign rsp.valid        = o_valid;
  assign rsp.kind         = o_kind;
  assign rsp.address      = o_addr;
  assign rsp.reg_index    = o_reg;
  assign rsp.load_op      = o_load;
  assign rsp.pc_plus_four = o_pc4;
  assign rsp.user_mode    = o_user;
  assign rsp.flush_pipe   = o_flush;
  assign rsp.restore_cpsr = o_restore;
  assign rsp.last         = o_last;

  assign adv = !o_valid || rsp.ready;
  assign pop = (state == ST_IDLE) && avail;

  always_comb begin
    sel       = d.up ? bts_pkg::lowest_set(rem) : bts_pkg::highest_set(rem);
    one_left  = ((rem & (rem - 16'h0001)) == 16'h0000);
    xfer_last = one_left && !d.wb_emit && !d.patch_emit;
    pc_sel    = (sel == bts_pkg::PC_REG);
    if (!one_left) begin
      xfer_next = ST_XFER;
    end else if (d.wb_emit) begin
      xfer_next = ST_WB;
    end else if (d.patch_emit) begin
      xfer_next = ST_PATCH;
    end else begin
      xfer_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (adv) begin
            o_valid <= 1'b0;
          end
          if (avail) begin
            d     <= desc;
            rem   <= desc.list;
            addr  <= desc.first_addr;
            state <= ST_XFER;
          end
        end
        ST_XFER: begin
          if (adv) begin
            o_valid   <= 1'b1;
            o_kind    <= bts_pkg::KIND_XFER;
            o_addr    <= addr;
            o_reg     <= sel;
            o_load    <= d.ld;
            o_pc4     <= !d.ld && pc_sel;
            o_user    <= d.user;
            o_flush   <= d.ld && pc_sel;
            o_restore <= d.restore && xfer_last;
            o_last    <= xfer_last;
            if (sel == d.rb) begin
              patch_addr <= addr;
            end
            rem   <= rem & ~(16'h0001 << sel);
            addr  <= d.up ? addr + bts_pkg::WORD_STEP : addr - bts_pkg::WORD_STEP;
            state <= xfer_next;
          end
        end
        ST_WB: begin
          if (adv) begin
            o_valid   <= 1'b1;
            o_kind    <= bts_pkg::KIND_WB;
            o_addr    <= d.new_base;
            o_reg     <= d.rb;
            o_load    <= 1'b0;
            o_pc4     <= 1'b0;
            o_user    <= d.user;
            o_flush   <= 1'b0;
            o_restore <= d.restore && !d.patch_emit;
            o_last    <= !d.patch_emit;
            state     <= d.patch_emit ? ST_PATCH : ST_IDLE;
          end
        end
        ST_PATCH: begin
          if (adv) begin
            o_valid   <= 1'b1;
            o_kind    <= bts_pkg::KIND_PATCH;
            o_addr    <= patch_addr;
            o_reg     <= d.rb;
            o_load    <= 1'b0;
            o_pc4     <= 1'b0;
            o_user    <= d.user;
            o_flush   <= 1'b0;
            o_restore <= d.restore;
            o_last    <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          if (adv) begin
            o_valid <= 1'b0;
          end
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/block_transfer_sequencer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_transfer_sequencer_core_tb: load/store multiple sequencer bench
// a walked table of block transfers, some with their words typed in, then
// random instructions; each result word is checked against its typed word or
// a predictor of the transfer order, addresses, writeback and patch store,
// with random stalls on both channels and one long stall on the result side
// ----------------------------------------------------------------------------
module block_transfer_sequencer_core_tb;

  localparam int RANDOM_ITEMS = 300;
  localparam int CALM_ITEMS   = 40;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        is_load;
    logic        pre_index;
    logic        step_up;
    logic        user_bank_bit;
    logic        write_back;
    logic [3:0]  base_reg;
    logic [15:0] reg_list;
    logic [31:0] base_value;
    logic        thumb_form;
  } instr_t;

  typedef struct packed {
    bts_pkg::kind_t kind;
    logic [31:0]    address;
    logic [3:0]     reg_index;
    logic           load_op;
    logic           pc_plus_four;
    logic           user_mode;
    logic           flush_pipe;
    logic           restore_cpsr;
    logic           last;
  } word_t;

  logic clk;
  logic rst;

  bts_req_if req_ch ();
  bts_rsp_if rsp_ch ();

  block_transfer_sequencer_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  word_t  pending_words [$];
  word_t  typed_words [$];
  instr_t table_instrs [$];
  int     table_typed [$];
  int     errors = 0;
  int     words_seen = 0;
  bit     calm = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic word_t mk_word(input bts_pkg::kind_t kind, input logic [31:0] address,
                                    input logic [3:0] reg_index, input logic load_op,
                                    input logic pc_plus_four, input logic user_mode,
                                    input logic flush_pipe, input logic restore_cpsr,
                                    input logic last);
    word_t w;
    w.kind         = kind;
    w.address      = address;
    w.reg_index    = reg_index;
    w.load_op      = load_op;
    w.pc_plus_four = pc_plus_four;
    w.user_mode    = user_mode;
    w.flush_pipe   = flush_pipe;
    w.restore_cpsr = restore_cpsr;
    w.last         = last;
    return w;
  endfunction

  function automatic instr_t mk_instr(input logic ld, input logic pre, input logic up,
                                      input logic s, input logic wb, input logic [3:0] rb,
                                      input logic [15:0] list, input logic [31:0] base,
                                      input logic th);
    instr_t ins;
    ins.is_load       = ld;
    ins.pre_index     = pre;
    ins.step_up       = up;
    ins.user_bank_bit = s;
    ins.write_back    = wb;
    ins.base_reg      = rb;
    ins.reg_list      = list;
    ins.base_value    = base;
    ins.thumb_form    = th;
    return ins;
  endfunction

  // expands one instruction into the words it should produce
  function automatic void predict_words(input instr_t ins);
    logic        ld, pre, up, s, wb, th, restore, user, inlist, first;
    logic [31:0] base, start, nb, span, a, k;
    logic [31:0] slot [16];
    logic [3:0]  rb, rg;
    word_t       seq [$];
    word_t       w;
    ld      = ins.is_load;
    pre     = ins.pre_index;
    up      = ins.step_up;
    s       = ins.user_bank_bit;
    wb      = ins.write_back;
    th      = ins.thumb_form;
    rb      = ins.base_reg;
    base    = ins.base_value;
    restore = 1'b0;
    if (th) begin
      s  = 1'b0;
      wb = 1'b1;
    end
    if (ins.reg_list == '0) begin
      if (up) begin
        a = pre ? base + bts_pkg::WORD_STEP : base;
      end else begin
        a = pre ? base - bts_pkg::EMPTY_SPAN : base - bts_pkg::EMPTY_DOWN_POST;
      end
      seq.push_back(mk_word(bts_pkg::KIND_XFER, a, bts_pkg::PC_REG, ld, ~ld, 1'b0, ld,
                            1'b0, 1'b0));
      seq.push_back(mk_word(bts_pkg::KIND_WB,
                            up ? base + bts_pkg::EMPTY_SPAN : base - bts_pkg::EMPTY_SPAN,
                            rb, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    end else begin
      span = '0;
      for (int r = 0; r < 16; r++) begin
        if (ins.reg_list[r]) span = span + bts_pkg::WORD_STEP;
      end
      if (up) begin
        start = pre ? base + bts_pkg::WORD_STEP : base;
      end else begin
        start = pre ? base - span : base - span + bts_pkg::WORD_STEP;
      end
      nb = up ? base + span : base - span;
      k  = start;
      for (int r = 0; r < 16; r++) begin
        slot[r] = k;
        if (ins.reg_list[r]) k = k + bts_pkg::WORD_STEP;
      end
      restore = s & ld & ins.reg_list[15];
      user    = s & ~restore;
      for (int i = 0; i < 16; i++) begin
        rg = up ? 4'(i) : 4'(15 - i);
        if (ins.reg_list[rg]) begin
          seq.push_back(mk_word(bts_pkg::KIND_XFER, slot[rg], rg, ld,
                                ~ld & (rg == bts_pkg::PC_REG), user,
                                ld & (rg == bts_pkg::PC_REG), 1'b0, 1'b0));
        end
      end
      inlist = ins.reg_list[rb];
      first  = inlist && ((ins.reg_list & ((16'h1 << rb) - 16'h1)) == '0);
      if (wb) begin
        if (!(ld && inlist)) begin
          seq.push_back(mk_word(bts_pkg::KIND_WB, nb, rb, 1'b0, 1'b0, user, 1'b0, 1'b0,
                                1'b0));
        end
        if (!ld && !th && inlist && !first) begin
          seq.push_back(mk_word(bts_pkg::KIND_PATCH, slot[rb], rb, 1'b0, 1'b0, user, 1'b0,
                                1'b0, 1'b0));
        end
      end
    end
    w = seq.pop_back();
    w.restore_cpsr = restore;
    w.last         = 1'b1;
    seq.push_back(w);
    foreach (seq[j]) pending_words.push_back(seq[j]);
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    int     shape;
    ins.is_load       = 1'($urandom);
    ins.pre_index     = 1'($urandom);
    ins.step_up       = 1'($urandom);
    ins.user_bank_bit = 1'($urandom);
    ins.write_back    = 1'($urandom);
    ins.base_reg      = 4'($urandom);
    ins.thumb_form    = ($urandom_range(0, 3) == 0);
    shape = $urandom_range(0, 9);
    case (shape)
      0: ins.reg_list = '0;
      1: ins.reg_list = 16'hFFFF;
      2, 3: ins.reg_list = 16'h1 << $urandom_range(0, 15);
      4, 5: ins.reg_list = 16'($urandom & $urandom & $urandom);
      default: ins.reg_list = 16'($urandom);
    endcase
    if (ins.reg_list != '0 && $urandom_range(0, 2) == 0) ins.reg_list[ins.base_reg] = 1'b1;
    shape = $urandom_range(0, 7);
    case (shape)
      0: ins.base_value = '0;
      1: ins.base_value = '1;
      2: ins.base_value = 32'($urandom_range(0, 63));
      3: ins.base_value = 32'hFFFF_FFC0 | 32'($urandom_range(0, 63));
      default: ins.base_value = $urandom;
    endcase
    return ins;
  endfunction

  task automatic add_row(input instr_t ins, input int n_typed);
    table_instrs.push_back(ins);
    table_typed.push_back(n_typed);
  endtask

  // offers one instruction and books its words once it is taken
  task automatic send_instr(input instr_t ins, input int n_typed);
    req_ch.valid         <= 1'b1;
    req_ch.is_load       <= ins.is_load;
    req_ch.pre_index     <= ins.pre_index;
    req_ch.step_up       <= ins.step_up;
    req_ch.user_bank_bit <= ins.user_bank_bit;
    req_ch.write_back    <= ins.write_back;
    req_ch.base_reg      <= ins.base_reg;
    req_ch.reg_list      <= ins.reg_list;
    req_ch.base_value    <= ins.base_value;
    req_ch.thumb_form    <= ins.thumb_form;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (n_typed > 0) begin
      repeat (n_typed) pending_words.push_back(typed_words.pop_front());
    end else begin
      predict_words(ins);
    end
  endtask

  task automatic source_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  initial begin : source_side
    req_ch.valid         <= 1'b0;
    req_ch.is_load       <= 1'b0;
    req_ch.pre_index     <= 1'b0;
    req_ch.step_up       <= 1'b0;
    req_ch.user_bank_bit <= 1'b0;
    req_ch.write_back    <= 1'b0;
    req_ch.base_reg      <= '0;
    req_ch.reg_list      <= '0;
    req_ch.base_value    <= '0;
    req_ch.thumb_form    <= 1'b0;

    // empty list, store, ascending after
    add_row(mk_instr(0, 0, 1, 0, 0, 4'd2, 16'h0000, 32'h0000_1000, 0), 2);
    typed_words.push_back(mk_word(bts_pkg::KIND_XFER, 32'h0000_1000, 4'd15, 0, 1, 0, 0, 0,
                                  0));
    typed_words.push_back(mk_word(bts_pkg::KIND_WB, 32'h0000_1040, 4'd2, 0, 0, 0, 0, 0, 1));
    // empty list, load, descending before, wraps below zero
    add_row(mk_instr(1, 1, 0, 0, 0, 4'd15, 16'h0000, 32'h0000_0000, 0), 2);
    typed_words.push_back(mk_word(bts_pkg::KIND_XFER, 32'hFFFF_FFC0, 4'd15, 1, 0, 0, 1, 0,
                                  0));
    typed_words.push_back(mk_word(bts_pkg::KIND_WB, 32'hFFFF_FFC0, 4'd15, 0, 0, 0, 0, 0, 1));
    // one register at the top address
    add_row(mk_instr(1, 0, 1, 0, 0, 4'd1, 16'h0001, 32'hFFFF_FFFF, 0), 1);
    typed_words.push_back(mk_word(bts_pkg::KIND_XFER, 32'hFFFF_FFFF, 4'd0, 1, 0, 0, 0, 0,
                                  1));
    // pc store, ascending before, wraps to zero
    add_row(mk_instr(0, 1, 1, 0, 0, 4'd0, 16'h8000, 32'hFFFF_FFFC, 0), 1);
    typed_words.push_back(mk_word(bts_pkg::KIND_XFER, 32'h0000_0000, 4'd15, 0, 1, 0, 0, 0,
                                  1));

    add_row(mk_instr(1, 1, 1, 1, 1, 4'd6, 16'h0000, 32'h0000_2000, 0), 0);
    add_row(mk_instr(0, 0, 0, 0, 0, 4'd13, 16'h0000, 32'h0000_0010, 1), 0);
    add_row(mk_instr(1, 1, 1, 0, 1, 4'd3, 16'hFFFF, 32'h0000_0100, 0), 0);
    add_row(mk_instr(0, 0, 0, 0, 1, 4'd0, 16'hFFFF, 32'h0000_0000, 0), 0);
    add_row(mk_instr(0, 1, 0, 0, 1, 4'd5, 16'h00F0, 32'h0000_4000, 0), 0);
    add_row(mk_instr(0, 0, 1, 1, 1, 4'd10, 16'h8421, 32'h1234_5678, 0), 0);
    add_row(mk_instr(1, 0, 1, 1, 1, 4'd4, 16'h8003, 32'h0000_0800, 0), 0);
    add_row(mk_instr(1, 1, 0, 1, 1, 4'd9, 16'h00FF, 32'h0000_0900, 0), 0);
    add_row(mk_instr(0, 1, 0, 1, 0, 4'd2, 16'h8000, 32'h0000_0A00, 0), 0);
    add_row(mk_instr(1, 0, 1, 0, 0, 4'd1, 16'h00F2, 32'h0000_0B00, 1), 0);
    add_row(mk_instr(0, 0, 1, 1, 0, 4'd1, 16'h00F2, 32'h0000_0C00, 1), 0);
    add_row(mk_instr(0, 1, 0, 0, 0, 4'd13, 16'h40F0, 32'h0000_2000, 1), 0);
    add_row(mk_instr(1, 0, 1, 0, 0, 4'd13, 16'h80F0, 32'h0000_1FE8, 1), 0);
    add_row(mk_instr(0, 0, 1, 0, 1, 4'd15, 16'h000F, 32'h0000_0D00, 0), 0);
    add_row(mk_instr(0, 1, 1, 0, 1, 4'd15, 16'hFFFF, 32'hFFFF_FFF0, 0), 0);
    add_row(mk_instr(1, 0, 1, 0, 1, 4'd15, 16'h7FFF, 32'h0000_0000, 0), 0);
    add_row(mk_instr(0, 0, 1, 0, 0, 4'd3, 16'h0AAA, 32'h0000_0E00, 0), 0);
    add_row(mk_instr(1, 0, 0, 0, 1, 4'd2, 16'h5555, 32'h8000_0000, 0), 0);

    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (table_instrs[i]) begin
      send_instr(table_instrs[i], table_typed[i]);
      source_gap();
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_instr(rand_instr(), 0);
      source_gap();
    end
    req_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : sink_side
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!held && words_seen >= HOLD_AFTER) begin
        // long stall so the intake fills and back-pressures the sender
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0d address %0h reg %0d", rsp_ch.kind,
               rsp_ch.address, rsp_ch.reg_index);
        errors++;
      end else begin
        want = pending_words.pop_front();
        check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
        check_field("address", want.address, rsp_ch.address);
        check_field("reg_index", 32'(want.reg_index), 32'(rsp_ch.reg_index));
        check_field("load_op", 32'(want.load_op), 32'(rsp_ch.load_op));
        check_field("pc_plus_four", 32'(want.pc_plus_four), 32'(rsp_ch.pc_plus_four));
        check_field("user_mode", 32'(want.user_mode), 32'(rsp_ch.user_mode));
        check_field("flush_pipe", 32'(want.flush_pipe), 32'(rsp_ch.flush_pipe));
        check_field("restore_cpsr", 32'(want.restore_cpsr), 32'(rsp_ch.restore_cpsr));
        check_field("last", 32'(want.last), 32'(rsp_ch.last));
      end
    end
  end

  initial begin : watchdog
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bts_pkg.sv
sv/bts_req_if.sv
sv/bts_rsp_if.sv
sv/bts_front.sv
sv/bts_queue.sv
sv/bts_back.sv
sv/block_transfer_sequencer_core.sv
bench/block_transfer_sequencer_core_tb.sv
